### hdl/ftbd_pkg.sv
// Shared types and constants for the FSK tape bit and byte decoder.
// No dependencies; imported by every module of the decoder.
package ftbd_pkg;

   // Frame layout: start bit at position 0, data bits 1..8, stop bits at the top
   localparam int FRAME_BITS      = 13;
   localparam int FILL_WIDTH      = $clog2(FRAME_BITS + 1);
   localparam int STOP_BITS       = 3;
   localparam int DATA_BITS       = 8;
   localparam int COUNTER_WIDTH   = 16;

   // Field widths
   localparam int SAMPLE_WIDTH    = 16;
   localparam int PERIOD_WIDTH    = 10;
   localparam int COUNT_WIDTH     = 4;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 10;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_TONE_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_TONE_PERIOD  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_PER_BIT     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_PER_BIT      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE        = 3'd4;

   // Register reset values
   localparam logic [PERIOD_WIDTH-1:0] RST_ZERO_TONE_PERIOD = 10'd36;
   localparam logic [PERIOD_WIDTH-1:0] RST_ONE_TONE_PERIOD  = 10'd18;
   localparam logic [COUNT_WIDTH-1:0]  RST_ZERO_PER_BIT     = 4'd4;
   localparam logic [COUNT_WIDTH-1:0]  RST_ONE_PER_BIT      = 4'd8;
   localparam logic [COUNT_WIDTH-1:0]  RST_TOLERANCE        = 4'd3;

   // Configuration handed to the tone stage
   typedef struct packed {
      logic [PERIOD_WIDTH-1:0] zero_tone_period;
      logic [PERIOD_WIDTH-1:0] one_tone_period;
      logic [COUNT_WIDTH-1:0]  zero_periods_per_bit;
      logic [COUNT_WIDTH-1:0]  one_periods_per_bit;
      logic [COUNT_WIDTH-1:0]  period_tolerance;
   } cfg_type;

   // Per-sample result of the tone stage
   typedef struct packed {
      logic bit_ready;
      logic bit_value;
      logic period_unknown;
   } bit_evt_type;

endpackage

### hdl/fsk_tape_bit_and_byte_decoder_top.sv
// FSK tape bit and byte decoder: one result per audio sample.
// Each result passes through the input register and then the result register.
// Throughput: one request per cycle while rsp_stall is low; the state update sets the rate.
// Reset (synchronous, active high): clears tone and frame state, loads register defaults.
// Depends on ftbd_pkg, ftbd_tone and ftbd_frame.
module fsk_tape_bit_and_byte_decoder_top
   import ftbd_pkg::*;
#(
   parameter int CNT_WIDTH = COUNTER_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_bit_ready,
   output logic                           rsp_bit_value,
   output logic                           rsp_byte_ready,
   output logic [DATA_BITS-1:0]           rsp_byte_value,
   output logic                           rsp_period_unknown,
   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_write_data
);

   cfg_type                        cfg_ff;
   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic                           out_valid_ff, out_valid_in;
   bit_evt_type                    evt, evt_ff;
   logic                           byte_ready, byte_ready_ff;
   logic [DATA_BITS-1:0]           byte_value, byte_value_ff;
   logic                           advance, accept;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_tone_period     <= RST_ZERO_TONE_PERIOD;
         cfg_ff.one_tone_period      <= RST_ONE_TONE_PERIOD;
         cfg_ff.zero_periods_per_bit <= RST_ZERO_PER_BIT;
         cfg_ff.one_periods_per_bit  <= RST_ONE_PER_BIT;
         cfg_ff.period_tolerance     <= RST_TOLERANCE;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ZERO_TONE_PERIOD: cfg_ff.zero_tone_period <= csr_write_data;
            CSR_ONE_TONE_PERIOD:  cfg_ff.one_tone_period  <= csr_write_data;
            CSR_ZERO_PER_BIT: begin
               cfg_ff.zero_periods_per_bit <= csr_write_data[COUNT_WIDTH-1:0];
            end
            CSR_ONE_PER_BIT: begin
               cfg_ff.one_periods_per_bit <= csr_write_data[COUNT_WIDTH-1:0];
            end
            CSR_TOLERANCE: cfg_ff.period_tolerance <= csr_write_data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Advance the held request when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request sample
   always_ff @(posedge clock) begin
      if (accept) begin
         in_sample_ff <= req_sample;
      end
   end

   ftbd_tone #(
      .CNT_WIDTH (CNT_WIDTH)
   ) u_tone (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (in_sample_ff),
      .cfg     (cfg_ff),
      .evt     (evt)
   );

   ftbd_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .evt        (evt),
      .byte_ready (byte_ready),
      .byte_value (byte_value)
   );

   // Load the result register
   always_ff @(posedge clock) begin
      if (advance) begin
         evt_ff        <= evt;
         byte_ready_ff <= byte_ready;
         byte_value_ff <= byte_value;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_bit_ready      = evt_ff.bit_ready;
   assign rsp_bit_value      = evt_ff.bit_value;
   assign rsp_period_unknown = evt_ff.period_unknown;
   assign rsp_byte_ready     = byte_ready_ff;
   assign rsp_byte_value     = byte_value_ff;

endmodule

### hdl/ftbd_tone.sv
// Zero-crossing period measurement, tone classification and bit decision.
// Depends on ftbd_pkg (cfg_type, bit_evt_type, widths).
module ftbd_tone
   import ftbd_pkg::*;
#(
   parameter int CNT_WIDTH = COUNTER_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  cfg_type                        cfg,
   output bit_evt_type                    evt
);

   localparam int CMP_WIDTH = CNT_WIDTH + 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [CNT_WIDTH-1:0]   PERIOD_MAX = '1;

   logic signed [SAMPLE_WIDTH-1:0] prev_ff, prev_in;
   logic [CNT_WIDTH-1:0]           period_ff, period_in;
   logic [COUNT_WIDTH-1:0]         zero_cnt_ff, zero_cnt_in;
   logic [COUNT_WIDTH-1:0]         one_cnt_ff, one_cnt_in;

   logic                   crossing;
   logic [CMP_WIDTH-1:0]   len_lo;
   logic [CMP_WIDTH-1:0]   zero_c, one_c, mid_c, tol_c;
   logic [PERIOD_WIDTH:0]  period_sum;
   logic                   near_zero, near_one, near_mid;
   logic                   is_zero, is_one;
   logic [COUNT_WIDTH-1:0] zero_upd, one_upd, need0, need1;
   logic                   bit1, bit0;

   // Falling crossing: previous sample positive, this one not
   assign crossing = (prev_ff > 0) && (sample <= 0);

   // Window tests: len + tol >= centre and len <= centre + tol
   always_comb begin
      period_sum = {1'b0, cfg.zero_tone_period} + {1'b0, cfg.one_tone_period};
      len_lo     = {1'b0, period_ff};
      tol_c      = CMP_WIDTH'(cfg.period_tolerance);
      zero_c     = CMP_WIDTH'(cfg.zero_tone_period);
      one_c      = CMP_WIDTH'(cfg.one_tone_period);
      mid_c      = CMP_WIDTH'(period_sum[PERIOD_WIDTH:1]);
      near_zero  = (len_lo + tol_c >= zero_c) && (len_lo <= zero_c + tol_c);
      near_one   = (len_lo + tol_c >= one_c) && (len_lo <= one_c + tol_c);
      near_mid   = (len_lo + tol_c >= mid_c) && (len_lo <= mid_c + tol_c);
   end

   // Classify: zero tone first, then one tone, then midpoint by majority
   always_comb begin
      is_zero = 1'b0;
      is_one  = 1'b0;
      if (near_zero) begin
         is_zero = 1'b1;
      end else if (near_one) begin
         is_one = 1'b1;
      end else if (near_mid) begin
         is_one  = (one_cnt_ff > zero_cnt_ff);
         is_zero = !(one_cnt_ff > zero_cnt_ff);
      end
   end

   // Count tones, decide bits, clear counts on a bit
   always_comb begin
      zero_upd = zero_cnt_ff;
      one_upd  = one_cnt_ff;
      if (crossing && is_zero && zero_cnt_ff != COUNT_MAX) begin
         zero_upd = zero_cnt_ff + 1'b1;
      end
      if (crossing && is_one && one_cnt_ff != COUNT_MAX) begin
         one_upd = one_cnt_ff + 1'b1;
      end
      need1 = (cfg.one_periods_per_bit == '0) ? COUNT_WIDTH'(1) : cfg.one_periods_per_bit;
      need0 = (cfg.zero_periods_per_bit == '0) ? COUNT_WIDTH'(1) : cfg.zero_periods_per_bit;
      bit1  = crossing && (one_upd >= need1);
      bit0  = crossing && !bit1 && (zero_upd >= need0);

      evt.bit_ready      = bit1 || bit0;
      evt.bit_value      = bit1;
      evt.period_unknown = crossing && !is_zero && !is_one;

      zero_cnt_in = (bit1 || bit0) ? '0 : zero_upd;
      one_cnt_in  = (bit1 || bit0) ? '0 : one_upd;
      prev_in     = sample;
      if (crossing) begin
         period_in = CNT_WIDTH'(1);
      end else if (period_ff != PERIOD_MAX) begin
         period_in = period_ff + 1'b1;
      end else begin
         period_in = period_ff;
      end
   end

   // Advance state once per processed sample
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         period_ff   <= '0;
         zero_cnt_ff <= '0;
         one_cnt_ff  <= '0;
      end else if (advance) begin
         prev_ff     <= prev_in;
         period_ff   <= period_in;
         zero_cnt_ff <= zero_cnt_in;
         one_cnt_ff  <= one_cnt_in;
      end
   end

endmodule

### hdl/ftbd_frame.sv
// Frame window: shifts decoded bits in and recognizes a framed byte.
// Depends on ftbd_pkg (bit_evt_type, frame constants).
module ftbd_frame
   import ftbd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  bit_evt_type          evt,
   output logic                 byte_ready,
   output logic [DATA_BITS-1:0] byte_value
);

   logic [FRAME_BITS-1:0] window_ff, window_in, shifted;
   logic [FILL_WIDTH-1:0] fill_ff, fill_in, fill_inc;
   logic                  match;

   // Slide the newest bit in at the top; oldest bit sits at position 0
   always_comb begin
      shifted  = {evt.bit_value, window_ff[FRAME_BITS-1:1]};
      fill_inc = (fill_ff < FILL_WIDTH'(FRAME_BITS)) ? fill_ff + 1'b1 : fill_ff;
      match    = evt.bit_ready && (fill_inc >= FILL_WIDTH'(FRAME_BITS)) && !shifted[0]
                 && (&shifted[FRAME_BITS-1:FRAME_BITS-STOP_BITS]);

      byte_ready = match;
      byte_value = match ? shifted[DATA_BITS:1] : '0;

      window_in = window_ff;
      fill_in   = fill_ff;
      if (match) begin
         window_in = '0;
         fill_in   = '0;
      end else if (evt.bit_ready) begin
         window_in = shifted;
         fill_in   = fill_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
      end else if (advance) begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### bench/fsk_tape_bit_and_byte_decoder_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for fsk_tape_bit_and_byte_decoder_top: drives audio sample requests
// with random gaps and stalls, predicts every result in a local decoder model and compares.
// Depends on ftbd_pkg and the decoder RTL.
module fsk_tape_bit_and_byte_decoder_top_test;
   import ftbd_pkg::*;

   localparam int RESET_CYCLES   = 11;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_WAIT       = 17;
   localparam int RANDOM_PHASES  = 4;
   localparam int PHASE_ITEMS    = 40;
   localparam logic [4:0] ALL_REGS = 5'b11111;

   typedef enum int {TONE_ZERO, TONE_ONE, TONE_UNKNOWN} tone_type;

   typedef struct packed {
      logic                 bit_ready;
      logic                 bit_value;
      logic                 byte_ready;
      logic [DATA_BITS-1:0] byte_value;
      logic                 period_unknown;
   } tape_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_sample = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_bit_ready;
   logic                           rsp_bit_value;
   logic                           rsp_byte_ready;
   logic [DATA_BITS-1:0]           rsp_byte_value;
   logic                           rsp_period_unknown;
   logic                           csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]      csr_write_data = '0;

   // Decoder model: register copy and tone/frame state
   cfg_type                        model_cfg;
   logic signed [SAMPLE_WIDTH-1:0] last_sample;
   logic [COUNTER_WIDTH-1:0]       period_count;
   logic [COUNT_WIDTH-1:0]         zero_periods;
   logic [COUNT_WIDTH-1:0]         one_periods;
   logic [FRAME_BITS-1:0]          frame_window;
   logic [FILL_WIDTH-1:0]          frame_fill;

   logic signed [SAMPLE_WIDTH-1:0] sample_queue[$];
   tape_result_type                expected_results[$];
   int                             queued_count = 0;
   int                             error_count = 0;
   int                             send_wait = 0;
   int                             recv_wait = 0;
   bit                             send_calm = 1'b0;
   bit                             recv_calm = 1'b0;
   int                             quiet_cycles = 0;

   fsk_tape_bit_and_byte_decoder_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_bit_ready      (rsp_bit_ready),
      .rsp_bit_value      (rsp_bit_value),
      .rsp_byte_ready     (rsp_byte_ready),
      .rsp_byte_value     (rsp_byte_value),
      .rsp_period_unknown (rsp_period_unknown),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // A measured length matches a centre within the tolerance; a negative lower edge is zero
   function automatic bit near_period(int len, int centre);
      int tol;
      tol = int'(model_cfg.period_tolerance);
      return (len >= centre - tol) && (len <= centre + tol);
   endfunction

   // Advance the decoder model by one sample and return the result it produces
   function automatic tape_result_type decode_sample(logic signed [SAMPLE_WIDTH-1:0] s);
      tape_result_type r;
      tone_type        tone;
      int              need_one;
      int              need_zero;
      int              mid;
      r = '0;
      if (last_sample > 0 && s <= 0) begin
         mid = (int'(model_cfg.zero_tone_period) + int'(model_cfg.one_tone_period)) / 2;
         if (near_period(int'(period_count), int'(model_cfg.zero_tone_period))) begin
            tone = TONE_ZERO;
         end else if (near_period(int'(period_count), int'(model_cfg.one_tone_period))) begin
            tone = TONE_ONE;
         end else if (near_period(int'(period_count), mid)) begin
            tone = (one_periods > zero_periods) ? TONE_ONE : TONE_ZERO;
         end else begin
            tone = TONE_UNKNOWN;
         end
         need_one  = (model_cfg.one_periods_per_bit == 0) ? 1 :
                     int'(model_cfg.one_periods_per_bit);
         need_zero = (model_cfg.zero_periods_per_bit == 0) ? 1 :
                     int'(model_cfg.zero_periods_per_bit);
         period_count = '0;
         case (tone)
            TONE_ONE: begin
               if (one_periods != '1) one_periods++;
            end
            TONE_ZERO: begin
               if (zero_periods != '1) zero_periods++;
            end
            default: r.period_unknown = 1'b1;
         endcase
         if (int'(one_periods) >= need_one) begin
            r.bit_ready = 1'b1;
            r.bit_value = 1'b1;
         end else if (int'(zero_periods) >= need_zero) begin
            r.bit_ready = 1'b1;
         end
         // Shift the bit in at the top; test for a frame once the window is full
         if (r.bit_ready) begin
            zero_periods = '0;
            one_periods  = '0;
            frame_window = {r.bit_value, frame_window[FRAME_BITS-1:1]};
            if (frame_fill < FRAME_BITS) frame_fill++;
            if (frame_fill >= FRAME_BITS && !frame_window[0] &&
                &frame_window[FRAME_BITS-1:FRAME_BITS-STOP_BITS]) begin
               r.byte_ready = 1'b1;
               r.byte_value = frame_window[DATA_BITS:1];
               frame_window = '0;
               frame_fill   = '0;
            end
         end
      end
      last_sample = s;
      if (period_count != '1) period_count++;
      return r;
   endfunction

   function automatic int draw_wait(bit calm);
      if (calm) return 0;
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return int'($urandom_range(0, 2));
         default: return int'($urandom_range(0, MAX_WAIT));
      endcase
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Present queued samples; hold a stalled request, predict on every accept
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(decode_sample(req_sample));
         end
         if (req_valid && req_stall) begin
            // hold the stalled request as it is
         end else if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_valid  <= 1'b1;
            req_sample <= sample_queue.pop_front();
            if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            send_wait = draw_wait(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Accept results with random stalls and check each against the oldest prediction
   always @(posedge clock) begin
      tape_result_type got;
      tape_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_bit_ready, rsp_bit_value, rsp_byte_ready, rsp_byte_value,
                    rsp_period_unknown};
            if (expected_results.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               if (got.bit_ready !== want.bit_ready || got.bit_value !== want.bit_value ||
                   got.byte_ready !== want.byte_ready || got.byte_value !== want.byte_value ||
                   got.period_unknown !== want.period_unknown) begin
                  report_mismatch($sformatf(
                     "bit %b/%b byte %b/%h unknown %b, want bit %b/%b byte %b/%h unknown %b",
                     got.bit_ready, got.bit_value, got.byte_ready, got.byte_value,
                     got.period_unknown, want.bit_ready, want.bit_value, want.byte_ready,
                     want.byte_value, want.period_unknown));
               end
            end
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            recv_wait = draw_wait(recv_calm);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Drop the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Leaves the write enable high; load_registers lowers it after the last write
   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, int data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data[CSR_DATA_WIDTH-1:0];
      @(posedge clock);
   endtask

   task automatic load_registers(cfg_type c, logic [4:0] sel);
      if (sel[CSR_ZERO_TONE_PERIOD]) begin
         csr_write(CSR_ZERO_TONE_PERIOD, int'(c.zero_tone_period));
         model_cfg.zero_tone_period = c.zero_tone_period;
      end
      if (sel[CSR_ONE_TONE_PERIOD]) begin
         csr_write(CSR_ONE_TONE_PERIOD, int'(c.one_tone_period));
         model_cfg.one_tone_period = c.one_tone_period;
      end
      if (sel[CSR_ZERO_PER_BIT]) begin
         csr_write(CSR_ZERO_PER_BIT, int'(c.zero_periods_per_bit));
         model_cfg.zero_periods_per_bit = c.zero_periods_per_bit;
      end
      if (sel[CSR_ONE_PER_BIT]) begin
         csr_write(CSR_ONE_PER_BIT, int'(c.one_periods_per_bit));
         model_cfg.one_periods_per_bit = c.one_periods_per_bit;
      end
      if (sel[CSR_TOLERANCE]) begin
         csr_write(CSR_TOLERANCE, int'(c.period_tolerance));
         model_cfg.period_tolerance = c.period_tolerance;
      end
      csr_write_enable <= 1'b0;
   endtask

   // Wait until every request has been answered, then let the pipeline drain
   task automatic wait_idle();
      do @(posedge clock);
      while (sample_queue.size() != 0 || expected_results.size() != 0 || req_valid);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_sample(int value);
      sample_queue.push_back(value[SAMPLE_WIDTH-1:0]);
      queued_count++;
   endtask

   // One signal cycle: a non-positive run (its first sample is the falling crossing), then
   // a positive run
   task automatic push_period(int len);
      int high_run;
      if (len < 2) len = 2;
      high_run = int'($urandom_range(1, len - 1));
      repeat (len - high_run) push_sample(-int'($urandom_range(0, 32768)));
      repeat (high_run) push_sample(int'($urandom_range(1, 32767)));
   endtask

   // Enough tone periods for one bit, each jittered within the tolerance
   task automatic push_tone_bit(bit value);
      int centre;
      int count;
      int tol;
      centre = value ? int'(model_cfg.one_tone_period) : int'(model_cfg.zero_tone_period);
      count  = value ? int'(model_cfg.one_periods_per_bit) :
               int'(model_cfg.zero_periods_per_bit);
      tol    = int'(model_cfg.period_tolerance);
      if (count == 0) count = 1;
      repeat (count) push_period(centre + int'($urandom_range(0, 2 * tol)) - tol);
   endtask

   task automatic push_bits(logic [FRAME_BITS-1:0] frame, int length);
      for (int i = 0; i < length; i++) push_tone_bit(frame[i]);
   endtask

   // Mostly clean random frames, some after stray bits; the rest corrupted, cut short or noise
   task automatic run_random_traffic(int budget);
      logic [FRAME_BITS-1:0] frame;
      int                    start;
      start = queued_count;
      while (queued_count - start < budget) begin
         frame = {3'b111, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0};
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: push_bits(frame, FRAME_BITS);
            6: begin
               repeat ($urandom_range(1, 4)) push_tone_bit(1'($urandom_range(0, 1)));
               push_bits(frame, FRAME_BITS);
            end
            7: push_bits(frame ^ FRAME_BITS'($urandom_range(1, 8191)), FRAME_BITS);
            8: push_bits(frame, int'($urandom_range(1, FRAME_BITS - 1)));
            default: begin
               repeat ($urandom_range(1, 4)) begin
                  push_period(int'($urandom_range(2, 2 * (int'(model_cfg.zero_tone_period) +
                                                          int'(model_cfg.one_tone_period)))));
               end
            end
         endcase
      end
   endtask

   initial begin
      cfg_type c;
      int      one_len;
      int      tol;
      int      default_periods[] = '{36, 33, 39, 18, 15, 21, 27, 24, 30, 32, 40, 100};
      int      mixed_periods[]   = '{13, 11, 5, 7, 9, 9, 14, 6, 6, 12};

      model_cfg    = '{RST_ZERO_TONE_PERIOD, RST_ONE_TONE_PERIOD, RST_ZERO_PER_BIT,
                       RST_ONE_PER_BIT, RST_TOLERANCE};
      last_sample  = '0;
      period_count = '0;
      zero_periods = '0;
      one_periods  = '0;
      frame_window = '0;
      frame_fill   = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Sample extremes, then classification edges under the reset settings
      push_sample(32767);
      push_sample(-32768);
      push_sample(0);
      push_sample(1);
      push_sample(-1);
      push_sample(0);
      push_sample(32767);
      push_sample(0);
      foreach (default_periods[i]) push_period(default_periods[i]);

      // Short tones: both edges, midpoint toward each tone, unknown, one clean frame,
      // and a one-tone count left running
      wait_idle();
      c = '{zero_tone_period: 10'd12, one_tone_period: 10'd6, zero_periods_per_bit: 4'd2,
            one_periods_per_bit: 4'd3, period_tolerance: 4'd1};
      load_registers(c, ALL_REGS);
      foreach (mixed_periods[i]) push_period(mixed_periods[i]);
      push_bits({3'b111, 1'b0, 8'hA5, 1'b0}, FRAME_BITS);
      push_period(6);
      push_period(6);
      push_period(12);

      // Lower the one-tone count below the running count: bit at the next period
      wait_idle();
      c.one_periods_per_bit = 4'd1;
      load_registers(c, 5'b1 << CSR_ONE_PER_BIT);
      push_period(5);
      push_period(12);
      push_period(12);

      // Overlapping tones (zero wins) and zero periods-per-bit registers
      wait_idle();
      c = '{zero_tone_period: 10'd10, one_tone_period: 10'd12, zero_periods_per_bit: 4'd0,
            one_periods_per_bit: 4'd0, period_tolerance: 4'd2};
      load_registers(c, ALL_REGS);
      push_period(11);
      push_period(12);
      push_period(14);
      push_period(16);
      push_period(8);
      push_period(11);
      push_period(13);

      // Random settings with short, well separated tones
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         one_len = int'($urandom_range(4, 7));
         tol     = int'($urandom_range(0, 2));
         c.one_tone_period      = PERIOD_WIDTH'(one_len);
         c.zero_tone_period     = PERIOD_WIDTH'(one_len + 2 * tol + int'($urandom_range(2, 5)));
         c.period_tolerance     = COUNT_WIDTH'(tol);
         c.zero_periods_per_bit = COUNT_WIDTH'($urandom_range(1, 2));
         c.one_periods_per_bit  = COUNT_WIDTH'($urandom_range(1, 2));
         if ($urandom_range(0, 3) == 0) begin
            c.one_tone_period  = c.zero_tone_period;
            c.zero_tone_period = PERIOD_WIDTH'(one_len);
         end
         load_registers(c, ALL_REGS);
         run_random_traffic(PHASE_ITEMS);
      end

      // Extreme settings: longest zero tone, widest tolerance, most one periods per bit;
      // short periods clamp the lower window edge at zero
      wait_idle();
      c = '{zero_tone_period: 10'd1023, one_tone_period: 10'd4, zero_periods_per_bit: 4'd1,
            one_periods_per_bit: 4'd15, period_tolerance: 4'd15};
      load_registers(c, ALL_REGS);
      repeat (16) push_period(int'($urandom_range(2, 19)));
      push_period(20);
      push_period(100);

      // Extreme settings the other way round, zero tolerance
      wait_idle();
      c = '{zero_tone_period: 10'd4, one_tone_period: 10'd1023, zero_periods_per_bit: 4'd15,
            one_periods_per_bit: 4'd1, period_tolerance: 4'd0};
      load_registers(c, ALL_REGS);
      repeat (15) push_period(4);
      push_period(5);
      push_period(3);
      push_period(4);

      wait_idle();
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
